// ===== rtl/core/tpt_pkg.sv =====
`default_nettype none

package tpt_pkg;

  // Sizes of the translator
  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BITS   = 8;
  localparam int OFFSET_BITS = 8;
  localparam int VA_W        = PAGE_BITS + OFFSET_BITS;
  localparam int NUM_PAGES   = 1 << PAGE_BITS;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int RANK_W      = TLB_IDX_W;
  localparam int FILL_W      = $clog2(TLB_ENTRIES + 1);

  typedef logic [VA_W-1:0]        va_t;
  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [TLB_IDX_W-1:0]   tlb_idx_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [FILL_W-1:0]      fill_t;

endpackage

`default_nettype wire

// ===== rtl/core/tpt_if.sv =====
`default_nettype none

// Request channel: one virtual address per word
interface tpt_req_if;
  import tpt_pkg::*;

  logic valid;
  logic ready;
  va_t  virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

// Response channel: one translation per word
interface tpt_rsp_if;
  import tpt_pkg::*;

  logic valid;
  logic ready;
  va_t  physical_address;
  logic tlb_hit;
  logic pg_fault;

  modport source (output valid, output physical_address, output tlb_hit,
                  output pg_fault, input ready);
  modport sink   (input valid, input physical_address, input tlb_hit,
                  input pg_fault, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlb_page_table_translator.sv =====
`default_nettype none

// Channel   Modport  Word                                          Handshake
// in_i      sink     virtual_address                               valid/ready
// out_o     source   physical_address, tlb_hit, pg_fault           valid/ready
//
// Each address is taken while idle, which starts the page table read; the scan then
// steps through the TLB slots one at a time through the single page/rank comparator,
// and the finish step updates the tables and loads the result register.
// in_i.ready is high only while idle; a result stalled on out_o holds the next
// update in ST_FINISH, so at most one more address is taken while a word waits.
// Reset clears the TLB, the present bits and the frame counter at once.
module tlb_page_table_translator (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpt_req_if.sink   in_i,
  tpt_rsp_if.source out_o
);
  import tpt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_e;

  state_e               state_q;
  va_t                  va_q;
  tlb_idx_t             idx_q;
  logic                 hit_q;
  tlb_idx_t             hit_slot_q;
  tlb_idx_t             victim_q;
  rank_t                vmax_q;
  fill_t                fill_q;
  logic [PAGE_BITS:0]   nff_q;
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  page_t                tlb_page_q  [TLB_ENTRIES];
  page_t                tlb_frame_q [TLB_ENTRIES];
  rank_t                tlb_rank_q  [TLB_ENTRIES];
  logic [NUM_PAGES-1:0] present_q;
  logic                 out_valid_q;
  va_t                  out_pa_q;
  logic                 out_hit_q;
  logic                 out_fault_q;

  logic     in_acc;
  page_t    cur_page;
  page_t    in_page;
  logic     scan_match;
  logic     scan_gt;
  logic     last_idx;
  logic     tlb_full;
  tlb_idx_t ins_slot;
  logic     pt_present;
  page_t    ram_rdata;
  page_t    miss_frame;
  page_t    res_frame;
  logic     fault;
  logic     commit;
  rank_t    old_rank;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cur_page = va_q[OFFSET_BITS +: PAGE_BITS];
  assign in_page  = in_i.virtual_address[OFFSET_BITS +: PAGE_BITS];

  // Shared comparator: one slot per cycle for the lookup and the LRU search
  assign scan_match = tlb_valid_q[idx_q] && (tlb_page_q[idx_q] == cur_page);
  assign scan_gt    = tlb_rank_q[idx_q] > vmax_q;
  assign last_idx   = idx_q == TLB_IDX_W'(TLB_ENTRIES - 1);

  // Replacement choice and frame selection
  assign tlb_full   = fill_q == FILL_W'(TLB_ENTRIES);
  assign ins_slot   = tlb_full ? victim_q : fill_q[TLB_IDX_W-1:0];
  assign pt_present = present_q[cur_page];
  assign miss_frame = pt_present ? ram_rdata : nff_q[PAGE_BITS-1:0];
  assign res_frame  = hit_q ? tlb_frame_q[hit_slot_q] : miss_frame;
  assign fault      = !hit_q && !pt_present;
  assign old_rank   = tlb_rank_q[hit_slot_q];
  assign commit     = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  // Page table frames; read started as the address is taken
  tpt_ram #(
    .WIDTH(PAGE_BITS),
    .DEPTH(NUM_PAGES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (commit && fault),
    .waddr_i(cur_page),
    .wdata_i(nff_q[PAGE_BITS-1:0]),
    .re_i   (in_acc),
    .raddr_i(in_page),
    .rdata_o(ram_rdata)
  );

  // Sequencer, TLB state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      va_q        <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      victim_q    <= '0;
      vmax_q      <= '0;
      fill_q      <= '0;
      nff_q       <= '0;
      tlb_valid_q <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
      out_pa_q    <= '0;
      out_hit_q   <= 1'b0;
      out_fault_q <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_page_q[i]  <= '0;
        tlb_frame_q[i] <= '0;
        tlb_rank_q[i]  <= '0;
      end
    end else begin
      if (out_valid_q && out_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            va_q     <= in_i.virtual_address;
            idx_q    <= '0;
            hit_q    <= 1'b0;
            victim_q <= '0;
            vmax_q   <= '0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // first matching slot wins
          if (scan_match && !hit_q) begin
            hit_q      <= 1'b1;
            hit_slot_q <= idx_q;
          end
          if (scan_gt) begin
            victim_q <= idx_q;
            vmax_q   <= tlb_rank_q[idx_q];
          end
          if (last_idx) begin
            state_q <= ST_FINISH;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            // age the other slots
            for (int i = 0; i < TLB_ENTRIES; i++) begin
              if (hit_q) begin
                if (TLB_IDX_W'(i) != hit_slot_q && tlb_valid_q[i] &&
                    tlb_rank_q[i] < old_rank) begin
                  tlb_rank_q[i] <= rank_t'(tlb_rank_q[i] + 1'b1);
                end
              end else if (TLB_IDX_W'(i) != ins_slot && tlb_valid_q[i]) begin
                tlb_rank_q[i] <= rank_t'(tlb_rank_q[i] + 1'b1);
              end
            end
            if (hit_q) begin
              tlb_rank_q[hit_slot_q] <= '0;
            end else begin
              tlb_valid_q[ins_slot] <= 1'b1;
              tlb_page_q[ins_slot]  <= cur_page;
              tlb_frame_q[ins_slot] <= miss_frame;
              tlb_rank_q[ins_slot]  <= '0;
              if (!tlb_full) begin
                fill_q <= fill_q + 1'b1;
              end
            end
            // fresh frame on a page fault, counter saturates past the last page
            if (fault) begin
              present_q[cur_page] <= 1'b1;
              if (!nff_q[PAGE_BITS]) begin
                nff_q <= nff_q + 1'b1;
              end
            end
            out_valid_q <= 1'b1;
            out_pa_q    <= {res_frame, va_q[OFFSET_BITS-1:0]};
            out_hit_q   <= hit_q;
            out_fault_q <= fault;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready             = state_q == ST_IDLE;
  assign out_o.valid            = out_valid_q;
  assign out_o.physical_address = out_pa_q;
  assign out_o.tlb_hit          = out_hit_q;
  assign out_o.pg_fault         = out_fault_q;

endmodule

`default_nettype wire

// ===== rtl/core/tpt_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module tpt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tpt_checker.sv =====
`default_nettype none

// Port-level checks on the translator
module tpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input tpt_pkg::va_t in_va_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input tpt_pkg::va_t out_pa_i,
  input logic        out_hit_i,
  input logic        out_fault_i
);
  import tpt_pkg::*;

  logic in_acc;
  va_t  in_va_seen;

  assign in_acc     = in_valid_i && in_ready_i;
  assign in_va_seen = in_va_i;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_pa_i) && $stable(out_hit_i) && $stable(out_fault_i))
    else $error("result word changed while stalled");

  // a TLB hit never also faults
  a_hit_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_hit_i && out_fault_i))
    else $error("hit and fault both set");

  // the lookup is busy right after an address is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_va_seen == in_va_i) |=> !in_ready_i)
    else $error("address taken while lookup in progress");

  // a new result only appears at the end of a lookup
  a_result_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a lookup");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_va_i    (in_i.virtual_address),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_pa_i   (out_o.physical_address),
  .out_hit_i  (out_o.tlb_hit),
  .out_fault_i(out_o.pg_fault)
);

`default_nettype wire
